/* design/i2dc_pkg.sv */
// Shared constants, widths and types of the 2-D int16 correlation core.
// No dependencies; the core top, i2dc_mac and i2dc_fifo import this package.
package i2dc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 7;
    localparam int MAX_HEIGHT = 4096;

    localparam int XW = $clog2(MAX_WIDTH);          // column counter bits
    localparam int YW = $clog2(MAX_HEIGHT);         // row counter bits
    localparam int KW = $clog2(MAX_KERNEL + 1);     // kernel size bits
    localparam int LB_LANES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int LB_WIDTH = 16 * LB_LANES;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_KERNEL_ROWS  = 2'd2,
        REG_KERNEL_COLS  = 2'd3
    } reg_idx_t;

    typedef logic [15:0] word_t;
    typedef word_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] kmat_t;

    typedef struct packed {
        logic produce;
        logic last_row;
        logic last_frame;
    } tag_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        last_row;
        logic        last_frame;
    } res_t;

    typedef struct packed {
        logic prod_busy;
        logic tree_busy;
    } mac_stat_t;

endpackage

/* design/i2dc_in_if.sv */
// Input channel of the correlation core: coefficient loads and pixels.
// No dependencies.
interface i2dc_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [2:0]         coef_row;
    logic [2:0]         coef_col;
    logic signed [15:0] sample_value;

    modport source (output valid, output operation, output coef_row, output coef_col,
                    output sample_value, input ready);
    modport sink (input valid, input operation, input coef_row, input coef_col,
                  input sample_value, output ready);
endinterface

/* design/i2dc_out_if.sv */
// Result channel of the correlation core.
// No dependencies.
interface i2dc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sum;
    logic               last_in_row;
    logic               last_in_frame;

    modport source (output valid, output sum, output last_in_row, output last_in_frame,
                    input ready);
    modport sink (input valid, input sum, input last_in_row, input last_in_frame,
                  output ready);
endinterface

/* design/image_2d_correlation_int16_core.sv */
// Top level of the streaming 2-D int16 valid-region correlation core.
// Depends on i2dc_pkg, i2dc_in_if, i2dc_out_if, i2dc_ram, i2dc_mac, i2dc_fifo.

// The core takes one item per clock: a coefficient load or a raster-order
// pixel, sustained back to back as long as the result channel keeps up. A
// result is offered on the result channel once the pixel that completes its
// window has passed the steps below, in order. The line RAM read (one read
// and one write of the line RAM per pixel) returns at the edge that accepts
// the pixel. Then come the window shift, the parallel multipliers, the row
// sums, and the final sum written into the result queue. An eight-entry result
// queue absorbs stalls; input ready drops only when queued plus in-flight
// results fill it. The line buffer needs no clearing pass after reset.
// Configure only while no item is in flight.
module image_2d_correlation_int16_core import i2dc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    i2dc_in_if.sink     samples,
    i2dc_out_if.source  results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  krows_reg;
    logic [2:0]  kcols_reg;
    reg_idx_t    widx;

    assign widx   = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            krows_reg  <= 3'd3;
            kcols_reg  <= 3'd3;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[12:0];
                REG_KERNEL_ROWS:  krows_reg  <= pwdata[2:0];
                REG_KERNEL_COLS:  kcols_reg  <= pwdata[2:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            REG_KERNEL_ROWS:  prdata = 32'(krows_reg);
            REG_KERNEL_COLS:  prdata = 32'(kcols_reg);
        endcase
    end

    // Clamped limits
    logic [XW:0]   w_lim;
    logic [YW:0]   h_lim;
    logic [KW-1:0] kr_lim, kc_lim;

    always_comb
    begin
        if (width_reg == '0)
            w_lim = (XW+1)'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_lim = (XW+1)'(MAX_WIDTH);
        else
            w_lim = (XW+1)'(width_reg);
        if (height_reg == '0)
            h_lim = (YW+1)'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_lim = (YW+1)'(MAX_HEIGHT);
        else
            h_lim = (YW+1)'(height_reg);
        if (krows_reg == '0)
            kr_lim = KW'(1);
        else if (32'(krows_reg) > 32'(MAX_KERNEL))
            kr_lim = KW'(MAX_KERNEL);
        else
            kr_lim = KW'(krows_reg);
        if (kcols_reg == '0)
            kc_lim = KW'(1);
        else if (32'(kcols_reg) > 32'(MAX_KERNEL))
            kc_lim = KW'(MAX_KERNEL);
        else
            kc_lim = KW'(kcols_reg);
    end

    // Accept and position counters
    logic accept, pixel_acc;
    logic [XW-1:0] col_reg, col_next, x_cur;
    logic [YW-1:0] row_reg, row_next, y_cur;
    logic [XW:0]   x_inc;
    logic [YW:0]   y_inc;
    tag_t          tag_now;

    assign accept    = samples.valid && samples.ready;
    assign pixel_acc = accept && (samples.operation == OP_PIXEL);

    always_comb
    begin
        x_cur = ({1'b0, col_reg} >= w_lim) ? '0 : col_reg;
        y_cur = ({1'b0, row_reg} >= h_lim) ? '0 : row_reg;
        x_inc = {1'b0, x_cur} + 1'b1;
        y_inc = {1'b0, y_cur} + 1'b1;
        tag_now.produce    = (32'(y_inc) >= 32'(kr_lim)) && (32'(x_inc) >= 32'(kc_lim));
        tag_now.last_row   = (x_inc == w_lim);
        tag_now.last_frame = (x_inc == w_lim) && (y_inc == h_lim);
        if (x_inc >= w_lim)
        begin
            col_next = '0;
            row_next = (y_inc >= h_lim) ? '0 : y_inc[YW-1:0];
        end
        else
        begin
            col_next = x_inc[XW-1:0];
            row_next = y_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pixel_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 0: line RAM read in flight
    logic              s0_valid_reg, s0_op_reg;
    logic [2:0]        s0_crow_reg, s0_ccol_reg;
    word_t             s0_value_reg;
    logic [XW-1:0]     s0_x_reg;
    tag_t              s0_tag_reg;
    logic              byp_valid_reg;
    logic [LB_WIDTH-1:0] byp_data_reg;

    logic                lb_we;
    logic [LB_WIDTH-1:0] lb_wdata, lb_rdata, lb_old;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= accept;
            // catch a write to the entry being read in the same cycle
            byp_valid_reg <= pixel_acc && lb_we && (s0_x_reg == x_cur);
        end
    end

    always_ff @(posedge clk)
    begin
        s0_op_reg    <= samples.operation;
        s0_crow_reg  <= samples.coef_row;
        s0_ccol_reg  <= samples.coef_col;
        s0_value_reg <= samples.sample_value;
        s0_x_reg     <= x_cur;
        s0_tag_reg   <= tag_now;
        byp_data_reg <= lb_wdata;
    end

    assign lb_we  = s0_valid_reg && (s0_op_reg == OP_PIXEL);
    assign lb_old = byp_valid_reg ? byp_data_reg : lb_rdata;

    always_comb
    begin
        lb_wdata = lb_old << 16;
        lb_wdata[15:0] = s0_value_reg;
    end

    i2dc_ram #(
        .WIDTH (LB_WIDTH),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (lb_we),
        .waddr (s0_x_reg),
        .wdata (lb_wdata),
        .raddr (x_cur),
        .rdata (lb_rdata)
    );

    // Window shift and stage 1
    kmat_t win_reg, coef_reg;
    logic  s1_valid_reg, s1_op_reg;
    logic [2:0] s1_crow_reg, s1_ccol_reg;
    word_t s1_value_reg;
    tag_t  s1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
            if (lb_we)
            begin
                for (int d = 0; d < MAX_KERNEL; d++)
                begin
                    for (int e = MAX_KERNEL - 1; e >= 1; e--)
                    begin
                        win_reg[d][e] <= win_reg[d][e-1];
                    end
                end
                win_reg[0][0] <= s0_value_reg;
                for (int d = 1; d < MAX_KERNEL; d++)
                begin
                    win_reg[d][0] <= lb_old[16*(d-1) +: 16];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= s0_op_reg;
        s1_crow_reg  <= s0_crow_reg;
        s1_ccol_reg  <= s0_ccol_reg;
        s1_value_reg <= s0_value_reg;
        s1_tag_reg   <= s0_tag_reg;
        // apply a load in program order, after the pixel ahead has read the store
        if (s1_valid_reg && (s1_op_reg == OP_LOAD))
        begin
            for (int r = 0; r < MAX_KERNEL; r++)
            begin
                for (int c = 0; c < MAX_KERNEL; c++)
                begin
                    if (32'(s1_crow_reg) == r && 32'(s1_ccol_reg) == c)
                    begin
                        coef_reg[r][c] <= s1_value_reg;
                    end
                end
            end
        end
    end

    // Multiply and sum
    logic      mac_go, mac_valid;
    res_t      mac_res;
    mac_stat_t mac_stat;

    assign mac_go = s1_valid_reg && (s1_op_reg == OP_PIXEL) && s1_tag_reg.produce;

    i2dc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mac_go),
        .tag       (s1_tag_reg),
        .window    (win_reg),
        .coef      (coef_reg),
        .krows     (kr_lim),
        .kcols     (kc_lim),
        .res_valid (mac_valid),
        .res       (mac_res),
        .stat      (mac_stat)
    );

    logic [FIFO_CW-1:0] fifo_count;
    logic [FIFO_CW:0]   pending;

    i2dc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mac_valid),
        .push_data (mac_res),
        .count     (fifo_count),
        .results   (results)
    );

    assign pending = (FIFO_CW+1)'(fifo_count)
                   + (FIFO_CW+1)'(s0_valid_reg && (s0_op_reg == OP_PIXEL) && s0_tag_reg.produce)
                   + (FIFO_CW+1)'(mac_go)
                   + (FIFO_CW+1)'(mac_stat.prod_busy)
                   + (FIFO_CW+1)'(mac_stat.tree_busy);

    assign samples.ready = (32'(pending) < 32'(FIFO_DEPTH));

    // Assertions
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending) <= 32'(FIFO_DEPTH))
        else $error("result queue overcommitted");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        mac_valid |-> (32'(fifo_count) < 32'(FIFO_DEPTH) || results.ready))
        else $error("push into a full result queue");

    a_bypass_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> (lb_we && $past(lb_we)))
        else $error("line buffer bypass without back-to-back pixels");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == OP_LOAD)) |=> !mac_stat.prod_busy)
        else $error("coefficient load started a result");

endmodule

/* design/i2dc_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module i2dc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/i2dc_mac.sv */
// Multiply stage and registered adder tree of the window sum.
// Depends on i2dc_pkg.
module i2dc_mac import i2dc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  tag_t             tag,
    input  kmat_t            window,
    input  kmat_t            coef,
    input  logic [KW-1:0]    krows,
    input  logic [KW-1:0]    kcols,
    output logic             res_valid,
    output res_t             res,
    output mac_stat_t        stat
);

    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][31:0] prod_reg, prod_next;
    logic [MAX_KERNEL-1:0][31:0]                 row_reg, row_next;
    logic prod_valid_reg, tree_valid_reg;
    tag_t prod_tag_reg, tree_tag_reg;

    // Coefficient (r,c) meets the pixel kr-1-r rows and kc-1-c columns back.
    always_comb
    begin
        word_t [MAX_KERNEL-1:0] row_sel;
        word_t px;
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            row_sel = '0;
            for (int i = 0; i < MAX_KERNEL; i++)
            begin
                if (int'(krows) - 1 - r == i)
                begin
                    row_sel = window[i];
                end
            end
            for (int c = 0; c < MAX_KERNEL; c++)
            begin
                px = '0;
                for (int j = 0; j < MAX_KERNEL; j++)
                begin
                    if (int'(kcols) - 1 - c == j)
                    begin
                        px = row_sel[j];
                    end
                end
                if (r < int'(krows) && c < int'(kcols))
                begin
                    prod_next[r][c] = 32'($signed(px) * $signed(coef[r][c]));
                end
                else
                begin
                    prod_next[r][c] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            row_next[r] = '0;
            for (int c = 0; c < MAX_KERNEL; c++)
            begin
                row_next[r] = row_next[r] + prod_reg[r][c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            tree_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= go;
            tree_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_tag_reg <= tag;
        row_reg      <= row_next;
        tree_tag_reg <= prod_tag_reg;
    end

    always_comb
    begin
        res.sum = '0;
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            res.sum = res.sum + row_reg[r];
        end
        res.last_row   = tree_tag_reg.last_row;
        res.last_frame = tree_tag_reg.last_frame;
    end

    assign res_valid      = tree_valid_reg;
    assign stat.prod_busy = prod_valid_reg;
    assign stat.tree_busy = tree_valid_reg;

endmodule

/* design/i2dc_fifo.sv */
// Result queue that parts the pipeline from the result channel.
// Depends on i2dc_pkg and i2dc_out_if.
module i2dc_fifo import i2dc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  res_t               push_data,
    output logic [FIFO_CW-1:0] count,
    i2dc_out_if.source         results
);

    res_t entries [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic pop;

    assign pop = results.valid && results.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign count                 = count_reg;
    assign results.valid         = (count_reg != '0);
    assign results.sum           = $signed(entries[rd_ptr_reg].sum);
    assign results.last_in_row   = entries[rd_ptr_reg].last_row;
    assign results.last_in_frame = entries[rd_ptr_reg].last_frame;

endmodule
